// ----- src/rsc_pkg.sv -----
package rsc_pkg;

    localparam int OP_W = 4;
    localparam int VAL_W = 32;
    localparam int STATUS_W = 2;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_NEG   = 4'd5,
        OP_DUP   = 4'd6,
        OP_SWAP  = 4'd7,
        OP_PEEK  = 4'd8,
        OP_CLEAR = 4'd9,
        OP_DUMP  = 4'd10
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FULL = 2'd2,
        ST_DIVZ = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_TOP = 2'd0,
        RD_SEC = 2'd1,
        RD_IDX = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_N  = 2'd0,
        WA_N1 = 2'd1,
        WA_N2 = 2'd2
    } wa_sel_t;

    typedef enum logic {
        WD_ALU = 1'b0,
        WD_B   = 1'b1
    } wd_sel_t;

    typedef enum logic [2:0] {
        RES_PV   = 3'd0,
        RES_ADD  = 3'd1,
        RES_SUB  = 3'd2,
        RES_NEG  = 3'd3,
        RES_A    = 3'd4,
        RES_B    = 3'd5,
        RES_ITER = 3'd6
    } res_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } cnt_op_t;

    typedef struct packed {
        logic     load_in;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     cap_b;
        logic     cap_a;
        logic     it_init;
        logic     it_div;
        logic     it_step;
        logic     res_load;
        res_sel_t res_sel;
        logic     wr_en;
        wa_sel_t  wa_sel;
        wd_sel_t  wd_sel;
        cnt_op_t  cnt_op;
        logic     idx_init;
        logic     idx_dec;
        logic     out_load;
        logic     out_dump;
        status_t  out_status;
        logic     out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic cnt_full;
        logic b_zero;
        logic it_done;
        logic idx_zero;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- src/rsc_dp.sv -----
module rsc_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [31:0]       push_value,
    input  rsc_pkg::dp_cmd_t         cmd,
    output rsc_pkg::dp_stat_t        stat,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       top_value,
    output logic                     has_value,
    output logic [1:0]               status,
    output logic                     last
);

    import rsc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         cnt_m2;
    logic [AW-1:0]         idx_reg;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [DATA_WIDTH-1:0] pv_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic [DATA_WIDTH-1:0] alu_val;

    logic [DATA_WIDTH-1:0] it_x_reg;
    logic [DATA_WIDTH-1:0] it_y_reg;
    logic [DATA_WIDTH-1:0] it_acc_reg;
    logic [IW-1:0]         it_cnt_reg;
    logic                  it_div_reg;
    logic                  neg_q_reg;
    logic [DATA_WIDTH:0]   div_shift;
    logic [DATA_WIDTH:0]   div_trial;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH-1:0] iter_val;

    logic                  out_valid_reg;
    logic signed [31:0]    out_val_reg;
    logic                  out_has_reg;
    logic [1:0]            out_status_reg;
    logic                  out_last_reg;
    logic                  out_has;

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TOP:  rd_addr = cnt_m1[AW-1:0];
            RD_SEC:  rd_addr = cnt_m2[AW-1:0];
            RD_IDX:  rd_addr = idx_reg;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wa_sel)
            WA_N:    wr_addr = count_reg[AW-1:0];
            WA_N1:   wr_addr = cnt_m1[AW-1:0];
            WA_N2:   wr_addr = cnt_m2[AW-1:0];
            default: wr_addr = count_reg[AW-1:0];
        endcase
    end

    assign iter_val = (it_div_reg && neg_q_reg) ? ('0 - it_acc_reg) : it_acc_reg;

    always_comb
    begin
        case (cmd.res_sel)
            RES_PV:   alu_val = pv_reg;
            RES_ADD:  alu_val = a_reg + b_reg;
            RES_SUB:  alu_val = a_reg - b_reg;
            RES_NEG:  alu_val = '0 - b_reg;
            RES_A:    alu_val = a_reg;
            RES_B:    alu_val = b_reg;
            RES_ITER: alu_val = iter_val;
            default:  alu_val = b_reg;
        endcase
    end

    assign wr_data = (cmd.wd_sel == WD_B) ? b_reg : alu_val;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CW'(1);
            CNT_DEC:  count_next = cnt_m1;
            CNT_CLR:  count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The divider works on magnitudes; the quotient sign is applied at the end.
    assign mag_a = a_reg[DATA_WIDTH-1] ? ('0 - a_reg) : a_reg;
    assign mag_b = b_reg[DATA_WIDTH-1] ? ('0 - b_reg) : b_reg;
    assign div_shift = {it_x_reg, it_acc_reg[DATA_WIDTH-1]};
    assign div_trial = div_shift - {1'b0, it_y_reg};

    assign out_has = cmd.out_dump | ~stat.cnt_zero;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pv_reg <= DATA_WIDTH'(push_value);
        end
        if (cmd.cap_b)
        begin
            b_reg <= rd_data_reg;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rd_data_reg;
        end
        if (cmd.res_load)
        begin
            res_reg <= alu_val;
        end
        if (cmd.idx_init)
        begin
            idx_reg <= cnt_m1[AW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (cmd.it_init)
        begin
            it_div_reg <= cmd.it_div;
            it_cnt_reg <= IW'(DATA_WIDTH);
            neg_q_reg <= a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
            if (cmd.it_div)
            begin
                it_x_reg <= '0;
                it_y_reg <= mag_b;
                it_acc_reg <= mag_a;
            end
            else
            begin
                it_x_reg <= a_reg;
                it_y_reg <= b_reg;
                it_acc_reg <= '0;
            end
        end
        else if (cmd.it_step)
        begin
            it_cnt_reg <= it_cnt_reg - IW'(1);
            if (it_div_reg)
            begin
                if (!div_trial[DATA_WIDTH])
                begin
                    it_x_reg <= div_trial[DATA_WIDTH-1:0];
                    it_acc_reg <= {it_acc_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    it_x_reg <= div_shift[DATA_WIDTH-1:0];
                    it_acc_reg <= {it_acc_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                if (it_y_reg[0])
                begin
                    it_acc_reg <= it_acc_reg + it_x_reg;
                end
                it_x_reg <= {it_x_reg[DATA_WIDTH-2:0], 1'b0};
                it_y_reg <= {1'b0, it_y_reg[DATA_WIDTH-1:1]};
            end
        end
        if (cmd.out_load)
        begin
            out_has_reg <= out_has;
            out_status_reg <= cmd.out_status;
            out_last_reg <= cmd.out_last;
            if (cmd.out_dump)
            begin
                out_val_reg <= 32'($signed(rd_data_reg));
            end
            else if (out_has)
            begin
                out_val_reg <= 32'($signed(res_reg));
            end
            else
            begin
                out_val_reg <= '0;
            end
        end
    end

    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_lt2 = (count_reg < CW'(2));
    assign stat.cnt_full = (count_reg == CW'(STACK_DEPTH));
    assign stat.b_zero = (b_reg == '0);
    assign stat.it_done = (it_cnt_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = ~out_valid_reg | ~out_stall;

    assign out_valid = out_valid_reg;
    assign top_value = out_val_reg;
    assign has_value = out_has_reg;
    assign status = out_status_reg;
    assign last = out_last_reg;

endmodule

// ----- src/rsc_ctrl.sv -----
module rsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        operation,
    input  rsc_pkg::dp_stat_t stat,
    output rsc_pkg::dp_cmd_t  cmd
);

    import rsc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_RD_TOP    = 11'b000_0000_0010,
        S_RD_SEC    = 11'b000_0000_0100,
        S_CAP_A     = 11'b000_0000_1000,
        S_EXEC      = 11'b000_0001_0000,
        S_ITER      = 11'b000_0010_0000,
        S_FIN       = 11'b000_0100_0000,
        S_WR2       = 11'b000_1000_0000,
        S_EMIT      = 11'b001_0000_0000,
        S_DUMP_RD   = 11'b010_0000_0000,
        S_DUMP_EMIT = 11'b100_0000_0000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    op_t     op_reg;
    status_t status_reg;
    status_t status_next;
    logic    accept;
    logic    few;
    logic    full;
    logic    divz;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid & ~in_stall;

    always_comb
    begin
        case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: few = stat.cnt_lt2;
            OP_NEG, OP_DUP, OP_PEEK:                 few = stat.cnt_zero;
            default:                                 few = 1'b0;
        endcase
    end

    assign full = ((op_reg == OP_PUSH) || (op_reg == OP_DUP)) && !few && stat.cnt_full;
    assign divz = (op_reg == OP_DIV) && !few && stat.b_zero;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    state_next = S_RD_TOP;
                end
            end
            S_RD_TOP:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_TOP;
                state_next = S_RD_SEC;
            end
            S_RD_SEC:
            begin
                cmd.cap_b = 1'b1;
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_SEC;
                state_next = S_CAP_A;
            end
            S_CAP_A:
            begin
                cmd.cap_a = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_EMIT;
                status_next = few ? ST_FEW : full ? ST_FULL : divz ? ST_DIVZ : ST_OK;
                cmd.res_load = 1'b1;
                cmd.res_sel = RES_B;
                cmd.wd_sel = WD_ALU;
                if (!(few || full || divz))
                begin
                    case (op_reg)
                        OP_PUSH:
                        begin
                            cmd.res_sel = RES_PV;
                            cmd.wr_en = 1'b1;
                            cmd.wa_sel = WA_N;
                            cmd.cnt_op = CNT_INC;
                        end
                        OP_ADD, OP_SUB:
                        begin
                            cmd.res_sel = (op_reg == OP_ADD) ? RES_ADD : RES_SUB;
                            cmd.wr_en = 1'b1;
                            cmd.wa_sel = WA_N2;
                            cmd.cnt_op = CNT_DEC;
                        end
                        OP_MUL, OP_DIV:
                        begin
                            cmd.res_load = 1'b0;
                            cmd.it_init = 1'b1;
                            cmd.it_div = (op_reg == OP_DIV);
                            state_next = S_ITER;
                        end
                        OP_NEG:
                        begin
                            cmd.res_sel = RES_NEG;
                            cmd.wr_en = 1'b1;
                            cmd.wa_sel = WA_N1;
                        end
                        OP_DUP:
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wa_sel = WA_N;
                            cmd.cnt_op = CNT_INC;
                        end
                        OP_SWAP:
                        begin
                            cmd.res_sel = RES_A;
                            cmd.wr_en = 1'b1;
                            cmd.wa_sel = WA_N1;
                            state_next = S_WR2;
                        end
                        OP_CLEAR:
                        begin
                            cmd.cnt_op = CNT_CLR;
                        end
                        OP_DUMP:
                        begin
                            if (!stat.cnt_zero)
                            begin
                                cmd.idx_init = 1'b1;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            cmd.res_sel = RES_B;
                        end
                    endcase
                end
            end
            S_ITER:
            begin
                if (stat.it_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.it_step = 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel = RES_ITER;
                cmd.wr_en = 1'b1;
                cmd.wa_sel = WA_N2;
                cmd.wd_sel = WD_ALU;
                cmd.cnt_op = CNT_DEC;
                state_next = S_EMIT;
            end
            S_WR2:
            begin
                cmd.wr_en = 1'b1;
                cmd.wa_sel = WA_N2;
                cmd.wd_sel = WD_B;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = status_reg;
                    cmd.out_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_dump = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_last = stat.idx_zero;
                    if (stat.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_t'(operation);
        end
        status_reg <= status_next;
    end

endmodule

// ----- src/rpn_stack_calculator.sv -----
// Channel  Handshake            Payload
// in       in_valid, in_stall   operation, push_value
// out      out_valid, out_stall top_value, has_value, status, last
//
// One command is worked on at a time; a new transaction is taken once the
// previous command has handed its last result to the output register.
// Push, add, sub, negate, dup, peek and clear write the stack at most once; swap
// adds a second write. Multiply and divide run on the shared shift-add and
// restoring-division unit that handles one bit per cycle. Dump reads the entries
// from top to bottom through the single read port, one result per entry (one with
// has_value low if empty). Reset empties the stack; out_stall only holds results.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rsc_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH = rsc_pkg::DEF_DATA_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         operation,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] top_value,
    output logic               has_value,
    output logic [1:0]         status,
    output logic               last
);

    import rsc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    rsc_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (push_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .top_value  (top_value),
        .has_value  (has_value),
        .status     (status),
        .last       (last)
    );

endmodule
